// ===== rtl/topp_pkg.sv =====
// Package with shared types, constants and tables of the Telnet option-refusing parser.
`timescale 1ns / 1ps
`default_nettype none
package topp_pkg;

  localparam int CLIENT_COUNT = 4;
  localparam int CLIENT_W     = 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_W       = 4;

  localparam logic [7:0] B_IAC  = 8'hFF;
  localparam logic [7:0] B_DONT = 8'hFE;
  localparam logic [7:0] B_DO   = 8'hFD;
  localparam logic [7:0] B_WONT = 8'hFC;
  localparam logic [7:0] B_WILL = 8'hFB;
  localparam logic [7:0] B_SB   = 8'hFA;
  localparam logic [7:0] B_SE   = 8'hF0;

  localparam logic [7:0] OPT_ECHO  = 8'h01;
  localparam logic [7:0] OPT_SGA   = 8'h03;
  localparam logic [7:0] OPT_LINEM = 8'h22;

  localparam logic [STEP_W-1:0] REFUSE_LAST = 4'd2;
  localparam logic [STEP_W-1:0] GREET_LAST  = 4'd8;

  typedef enum logic [1:0] {
    OP_BYTE       = 2'd0,
    OP_CONNECT    = 2'd1,
    OP_DISCONNECT = 2'd2,
    OP_NONE       = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_DATA    = 3'd0,
    PH_IAC     = 3'd1,
    PH_OPTION  = 3'd2,
    PH_SUB     = 3'd3,
    PH_SUB_IAC = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    JOB_DATA   = 2'd0,
    JOB_REFUSE = 2'd1,
    JOB_GREET  = 2'd2
  } job_e;

  typedef enum logic {
    KIND_APP = 1'b0,
    KIND_TX  = 1'b1
  } kind_e;

  typedef struct packed {
    job_e                job;
    logic [CLIENT_W-1:0] client;
    logic [7:0]          data;
    logic                wont;
  } job_t;

  // Welcome sequence: IAC WILL ECHO, IAC WILL SGA, IAC WONT LINEMODE.
  function automatic logic [7:0] greet_byte(input logic [STEP_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0, 4'd3, 4'd6: b = B_IAC;
      4'd1, 4'd4:       b = B_WILL;
      4'd7:             b = B_WONT;
      4'd2:             b = OPT_ECHO;
      4'd5:             b = OPT_SGA;
      4'd8:             b = OPT_LINEM;
      default:          b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/topp_if.sv =====
// Channel interfaces for requests into and results out of the parser.
`timescale 1ns / 1ps
`default_nettype none
interface topp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [1:0] client;
  logic [7:0] rx_byte;
  modport source (output valid, output op, output client, output rx_byte, input ready);
  modport sink   (input valid, input op, input client, input rx_byte, output ready);
endinterface

interface topp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] dest_client;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output kind, output dest_client, output out_byte,
                  output last, input ready);
  modport sink   (input valid, input kind, input dest_client, input out_byte,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/topp_front.sv =====
// Front end: per-client Telnet parse state and classification into reply jobs.
`timescale 1ns / 1ps
`default_nettype none
module topp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  topp_in_if.sink            in_i,
  input  wire logic          push_ready_i,
  output logic               push_valid_o,
  output topp_pkg::job_t     push_job_o
);

  topp_pkg::phase_e phase_q [topp_pkg::CLIENT_COUNT];
  logic             wont_q  [topp_pkg::CLIENT_COUNT];

  topp_pkg::phase_e phase_d;
  logic             wont_d;
  logic             emit;
  logic             accept;
  logic             slot_ok;
  topp_pkg::phase_e cur_phase;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && push_ready_i;
  assign slot_ok    = int'(in_i.client) < topp_pkg::CLIENT_COUNT;
  assign cur_phase  = phase_q[in_i.client];

  always_comb begin
    phase_d               = cur_phase;
    wont_d                = wont_q[in_i.client];
    emit                  = 1'b0;
    push_job_o.job        = topp_pkg::JOB_DATA;
    push_job_o.client     = in_i.client;
    push_job_o.data       = in_i.rx_byte;
    push_job_o.wont       = wont_q[in_i.client];
    unique case (topp_pkg::op_e'(in_i.op))
      topp_pkg::OP_CONNECT: begin
        phase_d        = topp_pkg::PH_DATA;
        wont_d         = 1'b0;
        emit           = 1'b1;
        push_job_o.job = topp_pkg::JOB_GREET;
      end
      topp_pkg::OP_DISCONNECT: begin
        phase_d = topp_pkg::PH_DATA;
        wont_d  = 1'b0;
      end
      topp_pkg::OP_BYTE: begin
        unique case (cur_phase)
          topp_pkg::PH_DATA: begin
            if (in_i.rx_byte == topp_pkg::B_IAC) begin
              phase_d = topp_pkg::PH_IAC;
            end else begin
              emit = 1'b1;
            end
          end
          topp_pkg::PH_IAC: begin
            priority if (in_i.rx_byte == topp_pkg::B_IAC) begin
              phase_d = topp_pkg::PH_DATA;
              emit    = 1'b1;
            end else if (in_i.rx_byte == topp_pkg::B_DO ||
                         in_i.rx_byte == topp_pkg::B_DONT) begin
              phase_d = topp_pkg::PH_OPTION;
              wont_d  = 1'b1;
            end else if (in_i.rx_byte == topp_pkg::B_WILL ||
                         in_i.rx_byte == topp_pkg::B_WONT) begin
              phase_d = topp_pkg::PH_OPTION;
              wont_d  = 1'b0;
            end else if (in_i.rx_byte == topp_pkg::B_SB) begin
              phase_d = topp_pkg::PH_SUB;
            end else begin
              phase_d = topp_pkg::PH_DATA;
            end
          end
          topp_pkg::PH_OPTION: begin
            phase_d        = topp_pkg::PH_DATA;
            emit           = 1'b1;
            push_job_o.job = topp_pkg::JOB_REFUSE;
          end
          topp_pkg::PH_SUB: begin
            if (in_i.rx_byte == topp_pkg::B_IAC) begin
              phase_d = topp_pkg::PH_SUB_IAC;
            end
          end
          topp_pkg::PH_SUB_IAC: begin
            phase_d = (in_i.rx_byte == topp_pkg::B_SE) ? topp_pkg::PH_DATA
                                                      : topp_pkg::PH_SUB;
          end
          default: begin
            phase_d = topp_pkg::PH_DATA;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign push_valid_o = in_i.valid && slot_ok && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < topp_pkg::CLIENT_COUNT; i++) begin
        phase_q[i] <= topp_pkg::PH_DATA;
        wont_q[i]  <= 1'b0;
      end
    end else if (accept && slot_ok) begin
      phase_q[in_i.client] <= phase_d;
      wont_q[in_i.client]  <= wont_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/topp_fifo.sv =====
// Short job queue between the parser front end and the reply back end.
`timescale 1ns / 1ps
`default_nettype none
module topp_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  topp_pkg::job_t     push_job_i,
  output logic               pop_valid_o,
  input  wire logic          pop_i,
  output topp_pkg::job_t     pop_job_o
);

  topp_pkg::job_t                 mem_q [topp_pkg::QUEUE_DEPTH];
  logic [topp_pkg::QPTR_W-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [topp_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                           do_push, do_pop;

  localparam logic [topp_pkg::QPTR_W-1:0] PTR_TOP =
    topp_pkg::QPTR_W'(topp_pkg::QUEUE_DEPTH - 1);
  localparam logic [topp_pkg::QCNT_W-1:0] CNT_FULL =
    topp_pkg::QCNT_W'(topp_pkg::QUEUE_DEPTH);

  assign push_ready_o = cnt_q != CNT_FULL;
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_job_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == PTR_TOP) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? ((rd_q == PTR_TOP) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL) else $error("job queue count overflow");

  a_push_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("job queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q)) else $error("empty queue with pointer gap");

endmodule
`default_nettype wire

// ===== rtl/topp_back.sv =====
// Back end: expands queued jobs into data bytes and transmit reply bytes.
`timescale 1ns / 1ps
`default_nettype none
module topp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  topp_pkg::job_t     job_i,
  output logic               pop_o,
  topp_out_if.source         out_o
);

  logic [topp_pkg::STEP_W-1:0] step_q, step_d;
  logic                        is_last;
  logic                        fire;

  always_comb begin
    out_o.kind     = topp_pkg::KIND_TX;
    out_o.out_byte = job_i.data;
    is_last        = 1'b1;
    unique case (job_i.job)
      topp_pkg::JOB_DATA: begin
        out_o.kind = topp_pkg::KIND_APP;
      end
      topp_pkg::JOB_REFUSE: begin
        is_last = step_q == topp_pkg::REFUSE_LAST;
        if (step_q == '0) begin
          out_o.out_byte = topp_pkg::B_IAC;
        end else if (step_q == 4'd1) begin
          out_o.out_byte = job_i.wont ? topp_pkg::B_WONT : topp_pkg::B_DONT;
        end
      end
      topp_pkg::JOB_GREET: begin
        is_last        = step_q == topp_pkg::GREET_LAST;
        out_o.out_byte = topp_pkg::greet_byte(step_q);
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid       = job_valid_i;
  assign out_o.dest_client = job_i.client;
  assign out_o.last        = is_last;
  assign fire              = job_valid_i && out_o.ready;
  assign pop_o             = fire && is_last;

  always_comb begin
    step_d = step_q;
    if (fire) begin
      step_d = is_last ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/telnet_option_refusing_parser.sv =====
// Top level of the Telnet receive parser that refuses every option request.
// A request that produces output enters the job queue; the back end reads the queue head.
// Throughput: one request per cycle while the queue has room; each job holds the output.
// Refusals give three results and the connect welcome nine; a 4-entry job queue absorbs them.
// Reset: every client slot returns to the data phase and the job queue empties at once.
`timescale 1ns / 1ps
`default_nettype none
module telnet_option_refusing_parser (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  topp_in_if.sink    in_i,
  topp_out_if.source out_o
);

  // The front end keeps one parse phase and one refusal flag per client and turns
  // each request into at most one job: pass a data byte, refuse an option, or
  // send the welcome. Requests that the parser swallows (IAC, commands,
  // subnegotiation bytes, disconnects, ignored op codes) leave the queue untouched.
  logic           push_valid;
  logic           push_ready;
  topp_pkg::job_t push_job;

  // The queue lets the front end keep taking requests while the back end is
  // still spelling out a multi-byte reply or waits on a stalled sink.
  logic           job_valid;
  logic           job_pop;
  topp_pkg::job_t job_head;

  topp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_job_o   (push_job)
  );

  topp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (job_valid),
    .pop_i        (job_pop),
    .pop_job_o    (job_head)
  );

  // The back end walks a step counter over the head job and pops it with the
  // result that carries last.
  topp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .pop_o       (job_pop),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

// ===== sim/telnet_option_refusing_parser_checker.sv =====
// Checker that predicts the parser's results from accepted requests and compares them.
`timescale 1ns / 1ps
module telnet_option_refusing_parser_checker (
  input  logic clk_i,
  input  logic rst_ni,
  topp_in_if   req_i,
  topp_out_if  res_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    topp_pkg::kind_e               kind;
    logic [topp_pkg::CLIENT_W-1:0] client;
    logic [7:0]                    data;
    logic                          last;
  } reply_t;

  // Welcome sent on connect: IAC WILL ECHO, IAC WILL SGA, IAC WONT LINEMODE.
  localparam logic [0:8][7:0] WELCOME = {topp_pkg::B_IAC, topp_pkg::B_WILL, topp_pkg::OPT_ECHO,
                                         topp_pkg::B_IAC, topp_pkg::B_WILL, topp_pkg::OPT_SGA,
                                         topp_pkg::B_IAC, topp_pkg::B_WONT, topp_pkg::OPT_LINEM};

  topp_pkg::phase_e phase_q    [topp_pkg::CLIENT_COUNT];
  logic             refuse_wont[topp_pkg::CLIENT_COUNT];
  reply_t replies_due[$];
  reply_t got;
  reply_t want;
  int     fails = 0;
  int     due_count = 0;

  assign fail_count_o = fails;
  assign pending_o    = due_count;

  task automatic report_mismatch(input string msg);
    fails++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic add_reply(input topp_pkg::kind_e kind,
                           input logic [topp_pkg::CLIENT_W-1:0] c,
                           input logic [7:0] data, input logic last);
    reply_t r;
    r.kind   = kind;
    r.client = c;
    r.data   = data;
    r.last   = last;
    replies_due.push_back(r);
  endtask

  // Advances the parser of one client slot and queues the results it causes.
  task automatic predict_request(input topp_pkg::op_e op,
                                 input logic [topp_pkg::CLIENT_W-1:0] c,
                                 input logic [7:0] b);
    case (op)
      topp_pkg::OP_CONNECT: begin
        phase_q[c]     = topp_pkg::PH_DATA;
        refuse_wont[c] = 1'b0;
        for (int k = 0; k < 9; k++) add_reply(topp_pkg::KIND_TX, c, WELCOME[k], k == 8);
      end
      topp_pkg::OP_DISCONNECT: begin
        phase_q[c]     = topp_pkg::PH_DATA;
        refuse_wont[c] = 1'b0;
      end
      topp_pkg::OP_BYTE: begin
        case (phase_q[c])
          topp_pkg::PH_DATA: begin
            if (b == topp_pkg::B_IAC) phase_q[c] = topp_pkg::PH_IAC;
            else add_reply(topp_pkg::KIND_APP, c, b, 1'b1);
          end
          topp_pkg::PH_IAC: begin
            if (b == topp_pkg::B_IAC) begin
              phase_q[c] = topp_pkg::PH_DATA;
              add_reply(topp_pkg::KIND_APP, c, b, 1'b1);
            end else if (b == topp_pkg::B_DO || b == topp_pkg::B_DONT ||
                         b == topp_pkg::B_WILL || b == topp_pkg::B_WONT) begin
              refuse_wont[c] = (b == topp_pkg::B_DO || b == topp_pkg::B_DONT);
              phase_q[c]     = topp_pkg::PH_OPTION;
            end else if (b == topp_pkg::B_SB) begin
              phase_q[c] = topp_pkg::PH_SUB;
            end else begin
              phase_q[c] = topp_pkg::PH_DATA;
            end
          end
          topp_pkg::PH_OPTION: begin
            phase_q[c] = topp_pkg::PH_DATA;
            add_reply(topp_pkg::KIND_TX, c, topp_pkg::B_IAC, 1'b0);
            add_reply(topp_pkg::KIND_TX, c,
                      refuse_wont[c] ? topp_pkg::B_WONT : topp_pkg::B_DONT, 1'b0);
            add_reply(topp_pkg::KIND_TX, c, b, 1'b1);
          end
          topp_pkg::PH_SUB: begin
            if (b == topp_pkg::B_IAC) phase_q[c] = topp_pkg::PH_SUB_IAC;
          end
          topp_pkg::PH_SUB_IAC: begin
            phase_q[c] = (b == topp_pkg::B_SE) ? topp_pkg::PH_DATA : topp_pkg::PH_SUB;
          end
          default: begin
            phase_q[c] = topp_pkg::PH_DATA;
          end
        endcase
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < topp_pkg::CLIENT_COUNT; c++) begin
        phase_q[c]     = topp_pkg::PH_DATA;
        refuse_wont[c] = 1'b0;
      end
      replies_due.delete();
      due_count = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.kind   = topp_pkg::kind_e'(res_i.kind);
        got.client = res_i.dest_client;
        got.data   = res_i.out_byte;
        got.last   = res_i.last;
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("result with none expected (client %0d, byte %02h)",
                                    got.client, got.data));
        end else begin
          want = replies_due.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
          if (got.client !== want.client)
            report_mismatch($sformatf("client %0d, expected %0d", got.client, want.client));
          if (got.data !== want.data)
            report_mismatch($sformatf("client %0d byte %02h, expected %02h",
                                      want.client, got.data, want.data));
          if (got.last !== want.last)
            report_mismatch($sformatf("client %0d last %0d, expected %0d",
                                      want.client, got.last, want.last));
        end
      end
      if (req_i.valid && req_i.ready)
        predict_request(topp_pkg::op_e'(req_i.op), req_i.client, req_i.rx_byte);
      due_count = replies_due.size();
    end
  end

endmodule

// ===== sim/telnet_option_refusing_parser_tb.sv =====
// Testbench top for the Telnet option-refusing parser: stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module telnet_option_refusing_parser_tb;

  // The slowest legal run has every request causing nine results, each held up by the
  // longest stall, plus the longest idle gap per request; the limit below leaves a wide
  // margin for this run.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 430;
  localparam int CALM_ITEMS   = 60;

  logic clk_i;
  logic rst_ni;

  topp_in_if  req_if ();
  topp_out_if res_if ();

  int fail_count;
  int replies_pending;
  int cycle_count = 0;
  int sent = 0;
  bit calm_phase = 1'b0;
  bit bursty = 1'b1;
  bit drained_mid = 1'b0;

  telnet_option_refusing_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // The checker sees both channels; it owns the prediction and hands back a failure
  // count and the number of results still outstanding.
  telnet_option_refusing_parser_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (replies_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a run that hangs on a lost result or a stuck handshake ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("telnet_option_refusing_parser_tb failed");
    $finish;
  end

  // Result side. Stalls come in random bursts; the stall mode switches on and off at
  // random so that long stretches run without any, and the closing part of the run
  // never stalls.
  initial begin : result_sink
    int stall_left;
    int mode_left;
    bit stalls_on;
    stall_left   = 0;
    mode_left    = 0;
    stalls_on    = 1'b1;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        stalls_on = ($urandom_range(0, 3) != 0);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (stall_left == 0 && stalls_on && !calm_phase && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 7);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Presents one request, possibly after an idle burst, and holds it until accepted.
  // Valid stays high between back-to-back requests, so it gets one assignment per edge.
  task automatic send_request(input topp_pkg::op_e op, input logic [1:0] client,
                              input logic [7:0] data);
    int gap;
    if (!calm_phase && bursty && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      req_if.valid   <= 1'b0;
      req_if.op      <= 2'($urandom);
      req_if.client  <= 2'($urandom);
      req_if.rx_byte <= 8'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid   <= 1'b1;
    req_if.op      <= op;
    req_if.client  <= client;
    req_if.rx_byte <= data;
    do @(posedge clk_i); while (!req_if.ready);
    // Ignored op codes do not count toward the number of requests.
    if (op != topp_pkg::OP_NONE) sent++;
  endtask

  task automatic send_byte(input logic [1:0] client, input logic [7:0] data);
    send_request(topp_pkg::OP_BYTE, client, data);
  endtask

  // Drops valid and holds off until every predicted result has come back. The negedge
  // first lets the checker record the last acceptance before the count is read.
  task automatic drain_replies();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    wait (replies_pending == 0);
  endtask

  // One random Telnet exchange on a random client. Most are well-formed sequences with
  // random content; the rest are interrupted sequences, ignored op codes and raw noise.
  task automatic send_random_sequence();
    logic [1:0] c;
    logic [7:0] cmd;
    int n;
    c = 2'($urandom);
    case ($urandom_range(0, 12))
      0, 1, 2: begin
        // Plain data, anything but IAC.
        send_byte(c, 8'($urandom_range(0, 254)));
      end
      3: begin
        // A doubled IAC is a literal 0xFF data byte.
        send_byte(c, topp_pkg::B_IAC);
        send_byte(c, topp_pkg::B_IAC);
      end
      4, 5, 6: begin
        // Option negotiation, refused whatever the option code is.
        case ($urandom_range(0, 3))
          0:       cmd = topp_pkg::B_DO;
          1:       cmd = topp_pkg::B_DONT;
          2:       cmd = topp_pkg::B_WILL;
          default: cmd = topp_pkg::B_WONT;
        endcase
        send_byte(c, topp_pkg::B_IAC);
        send_byte(c, cmd);
        // Sometimes another client's byte lands in the middle; each slot keeps its state.
        if ($urandom_range(0, 5) == 0) send_byte(c + 2'd1, 8'($urandom));
        // Rarely the client drops before naming the option.
        if ($urandom_range(0, 9) == 0)
          send_request(topp_pkg::OP_DISCONNECT, c, 8'($urandom));
        send_byte(c, 8'($urandom));
      end
      7, 8: begin
        // Subnegotiation with random payload, escaped IACs included, closed by IAC SE.
        send_byte(c, topp_pkg::B_IAC);
        send_byte(c, topp_pkg::B_SB);
        n = $urandom_range(0, 4);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            send_byte(c, topp_pkg::B_IAC);
            send_byte(c, topp_pkg::B_IAC);
          end else begin
            send_byte(c, 8'($urandom_range(0, 254)));
          end
        end
        // An IAC followed by something other than SE keeps the parser in the payload.
        if ($urandom_range(0, 3) == 0) begin
          send_byte(c, topp_pkg::B_IAC);
          send_byte(c, 8'($urandom_range(0, 8'hEF)));
        end
        send_byte(c, topp_pkg::B_IAC);
        send_byte(c, topp_pkg::B_SE);
      end
      9: begin
        // Any other command after IAC returns to data.
        send_byte(c, topp_pkg::B_IAC);
        send_byte(c, 8'($urandom_range(0, 8'hF9)));
      end
      10: begin
        send_request(($urandom_range(0, 2) == 0) ? topp_pkg::OP_CONNECT
                                                 : topp_pkg::OP_DISCONNECT, c,
                     8'($urandom));
      end
      11: begin
        send_request(topp_pkg::OP_NONE, c, 8'($urandom));
      end
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) send_request(topp_pkg::op_e'($urandom_range(0, 3)), 2'($urandom),
                                8'($urandom));
      end
    endcase
  endtask

  initial begin
    req_if.valid   = 1'b0;
    req_if.op      = topp_pkg::OP_NONE;
    req_if.client  = 2'd0;
    req_if.rx_byte = 8'h00;
    rst_ni         = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: welcome on connect, a doubled IAC, each of the four option
    // commands, two of them with the extreme option codes, a subnegotiation with an
    // IAC and a non-SE byte inside, another command, a disconnect in the middle of a
    // command, and an ignored op code.
    send_request(topp_pkg::OP_CONNECT, 2'd0, 8'h00);
    send_byte(2'd0, topp_pkg::B_IAC);
    send_byte(2'd0, topp_pkg::B_IAC);
    send_byte(2'd1, topp_pkg::B_IAC);
    send_byte(2'd1, topp_pkg::B_DO);
    send_byte(2'd1, 8'h18);
    send_byte(2'd2, topp_pkg::B_IAC);
    send_byte(2'd2, topp_pkg::B_DONT);
    send_byte(2'd2, 8'h00);
    send_byte(2'd3, topp_pkg::B_IAC);
    send_byte(2'd3, topp_pkg::B_WILL);
    send_byte(2'd3, 8'hFF);
    send_byte(2'd0, topp_pkg::B_IAC);
    send_byte(2'd0, topp_pkg::B_WONT);
    send_byte(2'd0, 8'h22);
    send_byte(2'd1, topp_pkg::B_IAC);
    send_byte(2'd1, topp_pkg::B_SB);
    send_byte(2'd1, topp_pkg::B_IAC);
    send_byte(2'd1, 8'h01);
    send_byte(2'd1, topp_pkg::B_IAC);
    send_byte(2'd1, topp_pkg::B_SE);
    send_byte(2'd1, 8'hFE);
    send_byte(2'd2, topp_pkg::B_IAC);
    send_byte(2'd2, 8'hF1);
    send_byte(2'd2, 8'h80);
    send_byte(2'd3, topp_pkg::B_IAC);
    send_request(topp_pkg::OP_DISCONNECT, 2'd3, 8'hFF);
    send_byte(2'd3, 8'h00);
    send_request(topp_pkg::OP_NONE, 2'd0, 8'hFF);
    drain_replies();

    // Random part. Idle bursts on the request side switch on and off every fifty
    // requests; the last stretch runs flat out on both sides, and halfway through the
    // sender stops once to let every outstanding result come home.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 50 == 0) bursty = ($urandom_range(0, 2) != 0);
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm_phase = 1'b1;
      if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
        drain_replies();
        drained_mid = 1'b1;
      end
      send_random_sequence();
    end

    drain_replies();
    // A few more cycles catch any result the block would send beyond what was expected.
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("telnet_option_refusing_parser_tb passed");
    end else begin
      $display("telnet_option_refusing_parser_tb failed");
    end
    $finish;
  end

endmodule
